// ===== design/source_tokenizer_core_assert.svh =====
// Assertion macros shared by the tokenizer RTL files.
`ifndef SOURCE_TOKENIZER_CORE_ASSERT_SVH
`define SOURCE_TOKENIZER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define STC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tokenizer assertion failed");
`define STC_NEVER(lbl, cond) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("tokenizer forbidden condition seen");
`else
`define STC_ASSERT(lbl, prop)
`define STC_NEVER(lbl, cond)
`endif
`endif

// ===== design/srctok_pkg.sv =====
// Types, token kinds, character codes and keyword table of the source tokenizer.
`default_nettype none
package srctok_pkg;

	localparam int START_W = 20;
	localparam int LEN_W = 8;
	localparam int KW_COUNT = 10;

	typedef logic [5:0] kind_t;
	typedef logic [5:0][7:0] word_t;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_NUM,
		MODE_WORD,
		MODE_MINUS,
		MODE_EQ,
		MODE_BANG,
		MODE_LT,
		MODE_GT
	} mode_t;

	localparam kind_t KIND_EOF    = 6'd0;
	localparam kind_t KIND_NUM    = 6'd1;
	localparam kind_t KIND_IDENT  = 6'd2;
	localparam kind_t KIND_I8     = 6'd3;
	localparam kind_t KIND_PLUS   = 6'd13;
	localparam kind_t KIND_MINUS  = 6'd14;
	localparam kind_t KIND_ARROW  = 6'd15;
	localparam kind_t KIND_STAR   = 6'd16;
	localparam kind_t KIND_SLASH  = 6'd17;
	localparam kind_t KIND_AMP    = 6'd18;
	localparam kind_t KIND_ASSIGN = 6'd19;
	localparam kind_t KIND_EQ     = 6'd20;
	localparam kind_t KIND_NE     = 6'd21;
	localparam kind_t KIND_LT     = 6'd22;
	localparam kind_t KIND_LE     = 6'd23;
	localparam kind_t KIND_GT     = 6'd24;
	localparam kind_t KIND_GE     = 6'd25;
	localparam kind_t KIND_LPAREN = 6'd26;
	localparam kind_t KIND_RPAREN = 6'd27;
	localparam kind_t KIND_LBRACE = 6'd28;
	localparam kind_t KIND_RBRACE = 6'd29;
	localparam kind_t KIND_COMMA  = 6'd30;
	localparam kind_t KIND_SEMI   = 6'd31;
	localparam kind_t KIND_COLON  = 6'd32;
	localparam kind_t KIND_AT     = 6'd33;
	localparam kind_t KIND_PIPE   = 6'd34;
	localparam kind_t KIND_ERR    = 6'd35;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_BANG = 8'h21;

	// Keyword spellings, first letter in the lowest byte, unused bytes zero.
	localparam word_t KW_TEXT [KW_COUNT] = '{
		{8'h00, 8'h00, 8'h00, 8'h00, "8", "i"},
		{8'h00, 8'h00, 8'h00, "6", "1", "i"},
		{8'h00, 8'h00, 8'h00, "2", "3", "i"},
		{8'h00, 8'h00, 8'h00, "4", "6", "i"},
		{8'h00, 8'h00, "d", "i", "o", "v"},
		{"n", "r", "u", "t", "e", "r"},
		{8'h00, "t", "n", "i", "r", "p"},
		{8'h00, 8'h00, 8'h00, 8'h00, "f", "i"},
		{8'h00, 8'h00, "e", "s", "l", "e"},
		{8'h00, "e", "l", "i", "h", "w"}
	};
	localparam logic [2:0] KW_LEN [KW_COUNT] = '{
		3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd6, 3'd5, 3'd2, 3'd4, 3'd5
	};

	typedef struct packed {
		kind_t             token_kind;
		logic [START_W-1:0] start_offset;
		logic [LEN_W-1:0]   token_length;
		logic [START_W-1:0] line_number;
		logic [7:0]         error_byte;
		logic               last_of_input;
	} res_t;

	// Up to two results produced by one source byte, first in r0.
	typedef struct packed {
		logic [1:0] cnt;
		res_t       r0;
		res_t       r1;
	} scan_res_t;

endpackage
`default_nettype wire

// ===== design/source_tokenizer_core.sv =====
// Top level of the streaming source tokenizer.
//
//   Channel | Direction | Signals                  | Contents
//   s_*     | in        | tvalid tready tdata[7:0] | one source byte, zero ends the source
//   m_*     | out       | tvalid tready tdata tlast| one token; tlast marks the last
//           |           |                          | token caused by a source byte
//
// A source byte is registered on transfer and decided once the two-entry result buffer has room
// for all of its tokens (none, one or two), which are then written into the buffer; its first
// token is offered on the output from the buffer's first slot.
// One byte is taken per cycle while the downstream side keeps up. The buffer absorbs the
// extra token of a byte that yields two, so the input stalls only when such a byte arrives
// while a token from an earlier byte is still waiting.
// Reset clears the scan mode, positions and line count; the line count restarts at one.
// The end-of-source byte also returns all scan state to its reset values.
// A stall on the output side backs up through the buffer into s_tready.
`default_nettype none
module source_tokenizer_core #(
	parameter int POSITION_BITS = 20,
	parameter int LENGTH_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] source_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] token_kind, [25:6] start_offset, [33:26] token_length,
	// [53:34] line_number, [61:54] error_byte, [63:62] zero
	output logic [63:0] m_tdata,
	output logic        m_tlast    // last_of_input
);
	import srctok_pkg::*;

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      buf_ready;
	logic      advance;
	scan_res_t scan_res;
	res_t      head;

	// The registered byte moves on once the buffer has room for all of its
	// tokens; a new byte is taken in the same cycle.
	assign advance = valid_s1 && buf_ready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	srctok_scan #(
		.POSITION_BITS(POSITION_BITS),
		.LENGTH_BITS  (LENGTH_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.byte_in(byte_s1),
		.advance(advance),
		.res    (scan_res)
	);

	srctok_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(valid_s1),
		.push_ready(buf_ready),
		.push      (scan_res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (head)
	);

	assign m_tdata = {2'b00, head.error_byte, head.line_number, head.token_length,
		head.start_offset, head.token_kind};
	assign m_tlast = head.last_of_input;

endmodule
`default_nettype wire

// ===== design/srctok_keyword.sv =====
// Parallel compare of the buffered word letters against the keyword table.
`default_nettype none
module srctok_keyword #(
	parameter int LENGTH_BITS = 8
) (
	input  srctok_pkg::word_t        letters,
	input  logic [LENGTH_BITS-1:0]   run_len,
	output srctok_pkg::kind_t        kind
);
	import srctok_pkg::*;

	always_comb begin
		logic match;
		kind = KIND_IDENT;
		for (int i = KW_COUNT - 1; i >= 0; i--) begin
			match = (run_len == LENGTH_BITS'(KW_LEN[i]));
			for (int j = 0; j < 6; j++) begin
				if (j < int'(KW_LEN[i]) && letters[j] != KW_TEXT[i][j]) begin
					match = 1'b0;
				end
			end
			if (match) begin
				kind = KIND_I8 + 6'(i);
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/srctok_scan.sv =====
// Scanner state and the per-byte token decision logic.
`default_nettype none
`include "source_tokenizer_core_assert.svh"
module srctok_scan #(
	parameter int POSITION_BITS = 20,
	parameter int LENGTH_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [7:0]            byte_in,
	input  logic                  advance,
	output srctok_pkg::scan_res_t res
);
	import srctok_pkg::*;

	mode_t                     mode_q, mode_d;
	logic [POSITION_BITS-1:0]  start_q, start_d;
	logic [POSITION_BITS-1:0]  pos_q, pos_d;
	logic [POSITION_BITS-1:0]  line_q, line_d;
	logic [LENGTH_BITS-1:0]    run_q, run_d;
	word_t                     letters_q;
	logic                      let_we;
	logic [2:0]                let_idx;
	kind_t                     word_kind;

	res_t  res_a, res_b;
	logic  have_a, have_b;
	logic  consumed, is_op, pair_hit, is_bang;
	kind_t single_k, pair_k;

	function automatic res_t mk(kind_t k, logic [POSITION_BITS-1:0] s,
			logic [LEN_W-1:0] l, logic [7:0] e, logic [POSITION_BITS-1:0] ln);
		res_t r;
		r.token_kind    = k;
		r.start_offset  = START_W'(s);
		r.token_length  = l;
		r.line_number   = START_W'(ln);
		r.error_byte    = e;
		r.last_of_input = 1'b0;
		return r;
	endfunction

	srctok_keyword #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_keyword (
		.letters(letters_q),
		.run_len(run_q),
		.kind   (word_kind)
	);

	always_comb begin
		res_a    = '0;
		res_b    = '0;
		have_a   = 1'b0;
		have_b   = 1'b0;
		consumed = 1'b0;
		is_op    = 1'b0;
		pair_hit = 1'b0;
		is_bang  = 1'b0;
		single_k = KIND_ERR;
		pair_k   = KIND_ERR;
		mode_d   = mode_q;
		start_d  = start_q;
		line_d   = line_q;
		run_d    = run_q;
		pos_d    = (pos_q == '1) ? pos_q : pos_q + 1'b1;
		let_we   = 1'b0;
		let_idx  = run_q[2:0];

		// Finish or extend the token that is pending from earlier bytes.
		unique case (mode_q)
			MODE_IDLE: begin
			end
			MODE_NUM: begin
				if (byte_in >= "0" && byte_in <= "9") begin
					consumed = 1'b1;
					run_d = (run_q == '1) ? run_q : run_q + 1'b1;
				end else begin
					have_a = 1'b1;
					res_a = mk(KIND_NUM, start_q, LEN_W'(run_q), 8'h00, line_q);
				end
			end
			MODE_WORD: begin
				if ((byte_in >= "a" && byte_in <= "z") || (byte_in >= "A" && byte_in <= "Z")
						|| (byte_in >= "0" && byte_in <= "9") || byte_in == "_") begin
					consumed = 1'b1;
					let_we = (run_q < LENGTH_BITS'(6));
					run_d = (run_q == '1) ? run_q : run_q + 1'b1;
				end else begin
					have_a = 1'b1;
					res_a = mk(word_kind, start_q, LEN_W'(run_q), 8'h00, line_q);
				end
			end
			MODE_MINUS: begin
				is_op = 1'b1; single_k = KIND_MINUS; pair_k = KIND_ARROW;
				pair_hit = (byte_in == ">");
			end
			MODE_EQ: begin
				is_op = 1'b1; single_k = KIND_ASSIGN; pair_k = KIND_EQ;
				pair_hit = (byte_in == "=");
			end
			MODE_BANG: begin
				is_op = 1'b1; is_bang = 1'b1; single_k = KIND_ERR; pair_k = KIND_NE;
				pair_hit = (byte_in == "=");
			end
			MODE_LT: begin
				is_op = 1'b1; single_k = KIND_LT; pair_k = KIND_LE;
				pair_hit = (byte_in == "=");
			end
			MODE_GT: begin
				is_op = 1'b1; single_k = KIND_GT; pair_k = KIND_GE;
				pair_hit = (byte_in == "=");
			end
		endcase

		if (is_op) begin
			have_a = 1'b1;
			if (pair_hit) begin
				consumed = 1'b1;
				res_a = mk(pair_k, start_q, LEN_W'(2), 8'h00, line_q);
			end else begin
				res_a = mk(single_k, start_q, LEN_W'(1), is_bang ? CH_BANG : 8'h00, line_q);
			end
		end

		if (!consumed || is_op) begin
			mode_d = MODE_IDLE;
		end

		// A byte not taken by the pending token starts something new.
		if (!consumed) begin
			case (byte_in) inside
				CH_NUL: begin
					have_b = 1'b1;
					res_b = mk(KIND_EOF, pos_q, LEN_W'(0), 8'h00, line_q);
				end
				CH_SP, CH_TAB, CH_CR: begin
				end
				CH_LF: line_d = (line_q == '1) ? line_q : line_q + 1'b1;
				"+": begin have_b = 1'b1; res_b.token_kind = KIND_PLUS;   end
				"*": begin have_b = 1'b1; res_b.token_kind = KIND_STAR;   end
				"/": begin have_b = 1'b1; res_b.token_kind = KIND_SLASH;  end
				"&": begin have_b = 1'b1; res_b.token_kind = KIND_AMP;    end
				"(": begin have_b = 1'b1; res_b.token_kind = KIND_LPAREN; end
				")": begin have_b = 1'b1; res_b.token_kind = KIND_RPAREN; end
				"{": begin have_b = 1'b1; res_b.token_kind = KIND_LBRACE; end
				"}": begin have_b = 1'b1; res_b.token_kind = KIND_RBRACE; end
				",": begin have_b = 1'b1; res_b.token_kind = KIND_COMMA;  end
				";": begin have_b = 1'b1; res_b.token_kind = KIND_SEMI;   end
				":": begin have_b = 1'b1; res_b.token_kind = KIND_COLON;  end
				"@": begin have_b = 1'b1; res_b.token_kind = KIND_AT;     end
				"|": begin have_b = 1'b1; res_b.token_kind = KIND_PIPE;   end
				"-": mode_d = MODE_MINUS;
				"=": mode_d = MODE_EQ;
				"!": mode_d = MODE_BANG;
				"<": mode_d = MODE_LT;
				">": mode_d = MODE_GT;
				["0":"9"]: mode_d = MODE_NUM;
				["a":"z"], ["A":"Z"], "_": begin
					mode_d = MODE_WORD;
					let_we = 1'b1;
					let_idx = 3'd0;
				end
				default: begin
					have_b = 1'b1;
					res_b.token_kind = KIND_ERR;
					res_b.error_byte = byte_in;
				end
			endcase

			// Single-byte tokens share offset, length and line.
			if (have_b && byte_in != CH_NUL) begin
				res_b.start_offset = START_W'(pos_q);
				res_b.token_length = LEN_W'(1);
				res_b.line_number = START_W'(line_q);
			end
			if (mode_d != MODE_IDLE) begin
				start_d = pos_q;
				run_d = LENGTH_BITS'(1);
			end
			if (byte_in == CH_NUL) begin
				mode_d = MODE_IDLE;
				start_d = '0;
				pos_d = '0;
				line_d = POSITION_BITS'(1);
				run_d = '0;
			end
		end

		if (have_b) begin
			res_b.last_of_input = 1'b1;
		end else begin
			res_a.last_of_input = 1'b1;
		end
		res.cnt = {1'b0, have_a} + {1'b0, have_b};
		res.r0 = have_a ? res_a : res_b;
		res.r1 = res_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			start_q <= '0;
			pos_q <= '0;
			line_q <= POSITION_BITS'(1);
			run_q <= '0;
		end else if (advance) begin
			mode_q <= mode_d;
			start_q <= start_d;
			pos_q <= pos_d;
			line_q <= line_d;
			run_q <= run_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && let_we) begin
			letters_q[let_idx] <= byte_in;
		end
	end

	`STC_ASSERT(a_eof_clears, (advance && byte_in == CH_NUL) |=> (pos_q == '0 && mode_q == MODE_IDLE))
	`STC_ASSERT(a_two_need_pending, (res.cnt == 2'd2) |-> (mode_q != MODE_IDLE))
	`STC_ASSERT(a_hold_stalled, !advance |=> (pos_q == $past(pos_q) && line_q == $past(line_q)))

endmodule
`default_nettype wire

// ===== design/srctok_outbuf.sv =====
// Two-entry result buffer that splits a byte's results into single transfers.
`default_nettype none
`include "source_tokenizer_core_assert.svh"
module srctok_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push_valid,
	output logic                  push_ready,
	input  srctok_pkg::scan_res_t push,
	output logic                  out_valid,
	input  logic                  out_ready,
	output srctok_pkg::res_t      out_data
);
	import srctok_pkg::*;

	res_t       slot0_q, slot1_q;
	logic [1:0] cnt_q;
	logic       pop, push_fire;
	logic [1:0] base_cnt;
	res_t       base0;

	assign out_valid = (cnt_q != 2'd0);
	assign out_data = slot0_q;
	assign pop = out_valid && out_ready;

	// What remains after this cycle's transfer, before new results land.
	assign base_cnt = cnt_q - {1'b0, pop};
	assign base0 = pop ? slot1_q : slot0_q;
	assign push_ready = ({1'b0, base_cnt} + {1'b0, push.cnt}) <= 3'd2;
	assign push_fire = push_valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= push_fire ? base_cnt + push.cnt : base_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire && base_cnt == 2'd0) begin
			slot0_q <= push.r0;
			slot1_q <= push.r1;
		end else begin
			slot0_q <= base0;
			// With both slots still occupied the second one must not be touched.
			if (push_fire && base_cnt == 2'd1) begin
				slot1_q <= push.r0;
			end
		end
	end

	`STC_NEVER(a_cnt_range, cnt_q == 2'd3)
	`STC_ASSERT(a_no_overflow, (cnt_q == 2'd2 && !pop) |-> !(push_fire && push.cnt != 2'd0))
	`STC_ASSERT(a_empty_push, (push_fire && push.cnt == 2'd0 && !pop) |=> (cnt_q == $past(cnt_q)))

endmodule
`default_nettype wire
